FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL modules of the Sobel edge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The expression must never be true while reset is released.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

FILE: sv/sem_pkg.sv
// Package with the sizes, register indexes and control structs of the Sobel edge block.
package sem_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = 13;
  localparam int OROW_W   = 12;
  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 9;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int GRAD_W   = 11;
  localparam int SQ_W     = 20;
  localparam int SUM_W    = 21;
  localparam int ROOT_W   = 18;

  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic grad;
    logic square;
    logic sum;
    logic root_step;
    logic publish;
  } sem_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic root_last;
    logic out_free;
  } sem_sts_t;

endpackage

FILE: sv/sem_ctrl.sv
// Controller state machine that sequences one word through the Sobel datapath.
`include "assert_macros.svh"

module sem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sem_pkg::sem_sts_t sts_i,
  output sem_pkg::sem_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_WIN  = 7'b0000010,
    ST_GRAD = 7'b0000100,
    ST_SQR  = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_ROOT = 7'b0100000,
    ST_DONE = 7'b1000000
  } sem_state_e;

  sem_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd_o.shift = 1'b1;
        state_d     = sts_i.emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait here only while the previous result still sits unread.
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CLK(a_accept_to_win, (in_valid_i && in_ready_o) |=> (state_q == ST_WIN),
              "accepted word did not move to the window step")
  `ASSERT_CLK(a_publish_free, cmd_o.publish |-> sts_i.out_free,
              "result published while the output register was occupied")
  `ASSERT_NEVER(a_root_no_load, cmd_o.root_step && cmd_o.load,
                "new word loaded during the square root")

endmodule

FILE: sv/sem_dp.sv
// Datapath with line stores, 3x3 window, gradient, square root and output register.
`include "assert_macros.svh"

module sem_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic [sem_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         mode_i,
  input  logic [sem_pkg::PIX_W-1:0]    pixel_value_i,
  input  sem_pkg::sem_cmd_t            cmd_i,
  output sem_pkg::sem_sts_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]    edge_magnitude_o,
  output logic                         last_of_frame_o
);

  localparam int COL_W    = sem_pkg::COL_W;
  localparam int ROW_W    = sem_pkg::ROW_W;
  localparam int OROW_W   = sem_pkg::OROW_W;
  localparam int PIX_W    = sem_pkg::PIX_W;
  localparam int WIDTH_W  = sem_pkg::WIDTH_W;
  localparam int HEIGHT_W = sem_pkg::HEIGHT_W;
  localparam int GRAD_W   = sem_pkg::GRAD_W;
  localparam int SQ_W     = sem_pkg::SQ_W;
  localparam int SUM_W    = sem_pkg::SUM_W;
  localparam int ROOT_W   = sem_pkg::ROOT_W;

  // Configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  width_sat;
  logic [HEIGHT_W-1:0] height_sat;

  // Position counters
  logic [COL_W-1:0]  icol_q, icol_d;
  logic [ROW_W-1:0]  irow_q, irow_d;
  logic [COL_W-1:0]  ocol_q, ocol_d;
  logic [OROW_W-1:0] orow_q, orow_d;

  // Line stores: mid holds the previous row, top the row before it.
  logic [PIX_W-1:0] top_mem [sem_pkg::MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [sem_pkg::MAX_WIDTH];
  logic [PIX_W-1:0] top_rd_q, mid_rd_q, pix_q;

  logic [PIX_W-1:0] win_q [9];

  logic left_ok_q, right_ok_q, top_ok_q, bottom_ok_q, last_q;
  logic [GRAD_W-1:0] tap [9];
  logic signed [GRAD_W-1:0] fx_d, fy_d, fx_q, fy_q;
  logic signed [2*GRAD_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]  sq_x_q, sq_y_q;
  logic [SUM_W-1:0] sum_full;
  logic             clamp_q;
  logic [ROOT_W-1:0] rem_q, root_q, bit_q;
  logic [ROOT_W:0]   trial;

  logic             out_valid_q;
  logic [PIX_W-1:0] edge_q;
  logic             edge_last_q;

  logic [WIDTH_W-1:0]  icol_ext, icol_next, ocol_ext, ocol_next;
  logic [HEIGHT_W-1:0] orow_next;
  logic                emit, row_end, out_row_end, out_last;

  // Configuration writes are saturated into the legal ranges; the width takes only the low nine bits of the write data.
  always_comb begin
    width_sat  = cfg_wdata_i[WIDTH_W-1:0];
    height_sat = cfg_wdata_i[HEIGHT_W-1:0];
    if (width_sat < WIDTH_W'(3)) begin
      width_sat = WIDTH_W'(3);
    end else if (width_sat > WIDTH_W'(sem_pkg::MAX_WIDTH)) begin
      width_sat = WIDTH_W'(sem_pkg::MAX_WIDTH);
    end
    if (height_sat < HEIGHT_W'(3)) begin
      height_sat = HEIGHT_W'(3);
    end else if (height_sat > HEIGHT_W'(sem_pkg::MAX_HEIGHT)) begin
      height_sat = HEIGHT_W'(sem_pkg::MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(256);
      height_q <= HEIGHT_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sem_pkg::REG_IMAGE_WIDTH:  width_q  <= width_sat;
        sem_pkg::REG_IMAGE_HEIGHT: height_q <= height_sat;
        default: ;
      endcase
    end
  end

  // Position bookkeeping
  assign icol_ext    = {1'b0, icol_q};
  assign icol_next   = icol_ext + WIDTH_W'(1);
  assign ocol_ext    = {1'b0, ocol_q};
  assign ocol_next   = ocol_ext + WIDTH_W'(1);
  assign orow_next   = {1'b0, orow_q} + HEIGHT_W'(1);
  assign row_end     = (icol_next >= width_q);
  assign out_row_end = (ocol_next >= width_q);
  assign out_last    = (orow_next >= height_q) && out_row_end;
  assign emit        = (irow_q >= ROW_W'(2)) || ((irow_q == ROW_W'(1)) && (icol_q != '0));

  always_comb begin
    icol_d = icol_q;
    irow_d = irow_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (cfg_we_i) begin
      icol_d = '0;
      irow_d = '0;
      ocol_d = '0;
      orow_d = '0;
    end else if (cmd_i.shift) begin
      if (row_end) begin
        icol_d = '0;
        if (irow_q != '1) begin
          irow_d = irow_q + ROW_W'(1);
        end
      end else begin
        icol_d = icol_next[COL_W-1:0];
      end
      if (emit) begin
        priority if (out_last) begin
          icol_d = '0;
          irow_d = '0;
          ocol_d = '0;
          orow_d = '0;
        end else if (out_row_end) begin
          ocol_d = '0;
          orow_d = orow_q + OROW_W'(1);
        end else begin
          ocol_d = ocol_next[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q <= '0;
      irow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      icol_q <= icol_d;
      irow_q <= irow_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

  // Line stores: read at accept, written back in the following cycle at the same column.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      top_rd_q <= top_mem[icol_q];
      mid_rd_q <= mid_mem[icol_q];
    end
    if (cmd_i.shift) begin
      top_mem[icol_q] <= mid_rd_q;
      mid_mem[icol_q] <= pix_q;
    end
  end

  // Window shift, border flags and the word itself.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= mode_i ? '0 : pixel_value_i;
    end
    if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= top_rd_q;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= mid_rd_q;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= pix_q;
      left_ok_q   <= (ocol_q != '0);
      right_ok_q  <= !out_row_end;
      top_ok_q    <= (orow_q != '0);
      bottom_ok_q <= (orow_next < height_q);
      last_q      <= out_last;
    end
  end

  // Taps outside the image read as zero.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      tap[k] = {{(GRAD_W-PIX_W){1'b0}}, win_q[k]};
      if ((k % 3 == 0) && !left_ok_q) tap[k] = '0;
      if ((k % 3 == 2) && !right_ok_q) tap[k] = '0;
      if ((k / 3 == 0) && !top_ok_q) tap[k] = '0;
      if ((k / 3 == 2) && !bottom_ok_q) tap[k] = '0;
    end
  end

  assign fx_d = signed'(tap[2] - tap[0]) + signed'((tap[5] - tap[3]) << 1)
              + signed'(tap[8] - tap[6]);
  assign fy_d = signed'(tap[6] - tap[0]) + signed'((tap[7] - tap[1]) << 1)
              + signed'(tap[8] - tap[2]);

  assign prod_x   = fx_q * fx_q;
  assign prod_y   = fy_q * fy_q;
  assign sum_full = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign trial    = {1'b0, root_q} + {1'b0, bit_q};

  // Gradient, squares, sum and a restoring square root, one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
    end
    if (cmd_i.square) begin
      sq_x_q <= prod_x[SQ_W-1:0];
      sq_y_q <= prod_y[SQ_W-1:0];
    end
    if (cmd_i.sum) begin
      // A root of 512 or more halves to above 255, so only 18 bits need the root.
      clamp_q <= (sum_full[SUM_W-1:ROOT_W] != '0);
      rem_q   <= sum_full[ROOT_W-1:0];
      root_q  <= '0;
      bit_q   <= ROOT_W'(1) << (ROOT_W - 2);
    end
    if (cmd_i.root_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q  <= rem_q - trial[ROOT_W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Output register lets the next word enter while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      edge_q      <= clamp_q ? '1 : root_q[PIX_W:1];
      edge_last_q <= last_q;
    end
  end

  assign sts_o.emit      = emit;
  assign sts_o.root_last = bit_q[0];
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign edge_magnitude_o = edge_q;
  assign last_of_frame_o  = edge_last_q;

  `ASSERT_CLK(a_icol_range, icol_ext < width_q, "input column beyond the row width")
  `ASSERT_CLK(a_ocol_range, ocol_ext < width_q, "output column beyond the row width")
  `ASSERT_CLK(a_root_fits, cmd_i.publish |-> (clamp_q || (root_q[ROOT_W-1:PIX_W+1] == '0)),
              "unclamped root does not fit the result")

endmodule

FILE: sv/sobel_edge_magnitude.sv
// A word that yields a result passes through these steps from accept to output valid:
// window update, gradient, squares, sum, nine square root steps and the output load.
// The block takes a new word only when it is through with the last one, which for a word
// that yields a result means after the bit-serial square root and the output load.
// Reset clears counters and control and sets width and height to 256; the line stores
// are not cleared, since taps outside the image are masked by position.
module sobel_edge_magnitude (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_index_i,
  input  logic [sem_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [sem_pkg::PIX_W-1:0]    pixel_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]    edge_magnitude_o,
  output logic                         last_of_frame_o
);

  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sem_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (mode_i),
    .pixel_value_i    (pixel_value_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .edge_magnitude_o (edge_magnitude_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule
